// ----- hdl/tpcq_pkg.sv -----
// ----------------------------------------------------------------------------
// tpcq_pkg: shared constants and types of the timed priority command queue
// Queue geometry, id bitmap geometry, request and status codes, slot layout,
// and the handshake structs between the sequencer and the id allocator.
// ----------------------------------------------------------------------------
package tpcq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int ID_SPACE    = 32768;
    localparam int Q_AW        = $clog2(QUEUE_DEPTH);
    localparam int Q_CW        = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = $clog2(ID_SPACE);
    localparam int WORD_W      = 32;
    localparam int ID_WORDS    = ID_SPACE / WORD_W;
    localparam int ID_WAW      = $clog2(ID_WORDS);
    localparam int ID_BW       = $clog2(WORD_W);
    localparam int ID_KW       = $clog2(ID_WORDS + 1);

    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_POP    = 3'd1;
    localparam logic [2:0] REQ_REMOVE = 3'd2;
    localparam logic [2:0] REQ_GROUP  = 3'd3;
    localparam logic [2:0] REQ_CLEAR  = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_NOID     = 3'd2;
    localparam logic [2:0] ST_NOTREADY = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic [2:0] ST_DENIED   = 3'd5;

    typedef struct packed {
        logic signed [7:0] prio;
        logic [31:0]       deadline;
        logic [ID_W-1:0]   job_id;
        logic [23:0]       actor;
        logic [23:0]       owner;
        logic [24:0]       cause;
        logic [31:0]       payload;
    } tpcq_slot_t;

    typedef struct packed {
        logic            alloc;
        logic            free;
        logic [ID_W-1:0] id;
    } tpcq_idreq_t;

    typedef struct packed {
        logic            ready;
        logic            done;
        logic            found;
        logic [ID_W-1:0] id;
    } tpcq_idrsp_t;

    typedef enum logic [2:0] {
        ID_CLEAR,
        ID_IDLE,
        ID_ARD,
        ID_AEV,
        ID_FRD,
        ID_FEV
    } tpcq_id_state_t;

    typedef enum logic [3:0] {
        TS_IDLE,
        TS_START,
        TS_INS_REQ,
        TS_INS_WAIT,
        TS_INS_RD,
        TS_INS_EV,
        TS_INS_WR,
        TS_SRCH_RD,
        TS_SRCH_EV,
        TS_CMP_RD,
        TS_CMP_EV,
        TS_CMP_FREE,
        TS_CMP_FWAIT,
        TS_DONE
    } tpcq_state_t;

endpackage

// ----- hdl/tpcq_ram.sv -----
// ----------------------------------------------------------------------------
// tpcq_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tpcq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/tpcq_idmap.sv -----
// ----------------------------------------------------------------------------
// tpcq_idmap: job id allocator
// Id-in-use bitmap kept as words in a RAM. Next-fit allocation scans one word
// at a time from the cursor, a read and then an evaluation per word, and wraps
// for a full lap; free is a read-modify-write. A clearing pass runs after reset.
// ----------------------------------------------------------------------------
module tpcq_idmap (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tpcq_pkg::tpcq_idreq_t req,
    output tpcq_pkg::tpcq_idrsp_t rsp
);
    import tpcq_pkg::*;

    tpcq_id_state_t     state_reg, state_next;
    logic [ID_WAW-1:0]  clr_reg, clr_next;
    logic [ID_KW-1:0]   k_reg, k_next;
    logic [ID_W-1:0]    cursor_reg, cursor_next;
    logic [ID_W-1:0]    fid_reg, fid_next;

    logic               we;
    logic [ID_WAW-1:0]  waddr, raddr;
    logic [WORD_W-1:0]  wdata, rdata;

    logic [ID_WAW-1:0]  scan_word;
    logic [ID_BW-1:0]   b0;
    logic [WORD_W-1:0]  low_mask, mask, free_bits;
    logic [ID_BW-1:0]   pos;

    tpcq_ram #(.WIDTH(WORD_W), .DEPTH(ID_WORDS)) u_map (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign b0        = cursor_reg[ID_BW-1:0];
    assign scan_word = cursor_reg[ID_W-1:ID_BW] + k_reg[ID_WAW-1:0];
    assign low_mask  = (WORD_W'(1) << b0) - WORD_W'(1);

    always_comb
    begin
        if (k_reg == ID_KW'(0))
        begin
            mask = ~low_mask;
        end
        else if (k_reg == ID_KW'(ID_WORDS))
        begin
            mask = low_mask;   // last lap: only ids below the cursor
        end
        else
        begin
            mask = '1;
        end
        free_bits = ~rdata & mask;
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (free_bits[i])
            begin
                pos = ID_BW'(i);
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        k_next      = k_reg;
        cursor_next = cursor_reg;
        fid_next    = fid_reg;
        we          = 1'b0;
        waddr       = scan_word;
        wdata       = '0;
        raddr       = scan_word;
        rsp.ready   = 1'b0;
        rsp.done    = 1'b0;
        rsp.found   = 1'b0;
        rsp.id      = {scan_word, pos};
        unique case (state_reg)
            ID_CLEAR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                clr_next = clr_reg + ID_WAW'(1);
                if (clr_reg == ID_WAW'(ID_WORDS - 1))
                begin
                    state_next = ID_IDLE;
                end
            end
            ID_IDLE:
            begin
                rsp.ready = 1'b1;
                if (req.alloc)
                begin
                    k_next     = '0;
                    state_next = ID_ARD;
                end
                else if (req.free)
                begin
                    fid_next   = req.id;
                    state_next = ID_FRD;
                end
            end
            ID_ARD:
            begin
                state_next = ID_AEV;
            end
            ID_AEV:
            begin
                if (|free_bits)
                begin
                    we          = 1'b1;
                    wdata       = rdata | (WORD_W'(1) << pos);
                    cursor_next = {scan_word, pos};
                    rsp.done    = 1'b1;
                    rsp.found   = 1'b1;
                    state_next  = ID_IDLE;
                end
                else if (k_reg == ID_KW'(ID_WORDS))
                begin
                    rsp.done   = 1'b1;
                    state_next = ID_IDLE;
                end
                else
                begin
                    k_next     = k_reg + ID_KW'(1);
                    state_next = ID_ARD;
                end
            end
            ID_FRD:
            begin
                raddr      = fid_reg[ID_W-1:ID_BW];
                state_next = ID_FEV;
            end
            ID_FEV:
            begin
                we         = 1'b1;
                waddr      = fid_reg[ID_W-1:ID_BW];
                wdata      = rdata & ~(WORD_W'(1) << fid_reg[ID_BW-1:0]);
                rsp.done   = 1'b1;
                state_next = ID_IDLE;
            end
            default:
            begin
                state_next = ID_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ID_CLEAR;
            clr_reg    <= '0;
            cursor_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            cursor_reg <= cursor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        fid_reg <= fid_next;
    end

endmodule

// ----- hdl/timed_priority_command_queue.sv -----
// ----------------------------------------------------------------------------
// timed_priority_command_queue: job queue ordered by priority and deadline
// Slots live in one RAM kept sorted; inserts shift from the tail, removals
// compact the list in one pass. Job ids come from a bitmap allocator.
// ----------------------------------------------------------------------------
//  channel | dir | signals                     | content
//  s_      | in  | tvalid tready tdata tuser   | request, tuser = req_type
//  m_      | out | tvalid tready tdata         | one result per request
//
//  Each slot visited is read, then evaluated; insert adds a read and an
//  evaluation per bitmap word scanned (up to ID_SPACE/32+1 words), and
//  removals add a free request and its wait per freed id. After reset the
//  id bitmap clearing pass writes ID_SPACE/32 words (1024) with s_tready low.
//  A new request is taken while a result still waits on m_.
// ----------------------------------------------------------------------------
module timed_priority_command_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // now_time[31:0] actor_id[55:32] owner_id[79:56] cause_id[104:80]
    // priority_req[112:105] delay[128:113] payload[160:129] target_id[175:161]
    // pop_limit[183:176] privileged[184], zero fill to 192
    input  logic [191:0] s_tdata,
    // req_type[2:0]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0] job_id[17:3] job_actor[41:18] job_cause[66:42]
    // job_payload[98:67] job_priority[106:99] removed_count[113:107], zero fill
    output logic [119:0] m_tdata
);
    import tpcq_pkg::*;

    tpcq_state_t        state_reg, state_next;
    logic [2:0]         req_reg, req_next;
    logic [31:0]        now_reg, now_next;
    logic [23:0]        actor_reg, actor_next;
    logic [23:0]        owner_reg, owner_next;
    logic [24:0]        cause_reg, cause_next;
    logic signed [7:0]  prio_reg, prio_next;
    logic [31:0]        dl_reg, dl_next;
    logic [31:0]        payload_reg, payload_next;
    logic [ID_W-1:0]    target_reg, target_next;
    logic signed [7:0]  limit_reg, limit_next;
    logic               priv_reg, priv_next;
    logic [Q_CW-1:0]    count_reg, count_next;
    logic [Q_CW-1:0]    idx_reg, idx_next;
    logic [Q_CW-1:0]    wr_reg, wr_next;
    logic [Q_CW-1:0]    pos_reg, pos_next;
    logic [Q_CW-1:0]    removed_reg, removed_next;
    logic [2:0]         res_status_reg, res_status_next;
    logic [ID_W-1:0]    res_id_reg, res_id_next;
    logic [23:0]        res_actor_reg, res_actor_next;
    logic [24:0]        res_cause_reg, res_cause_next;
    logic [31:0]        res_payload_reg, res_payload_next;
    logic [7:0]         res_prio_reg, res_prio_next;
    logic [ID_W-1:0]    free_id_reg, free_id_next;
    logic               out_valid_reg, out_valid_next;
    logic [119:0]       out_data_reg, out_data_next;

    logic               ram_we;
    logic [Q_AW-1:0]    ram_waddr, ram_raddr;
    tpcq_slot_t         ram_wdata, rd;
    logic [$bits(tpcq_slot_t)-1:0] rd_bits;

    tpcq_idreq_t        idreq;
    tpcq_idrsp_t        idrsp;

    logic [32:0]        dl_sum;
    logic [Q_CW-1:0]    idx_inc, idx_dec;
    logic               new_before, match, permit;
    tpcq_slot_t         new_slot;
    logic [6:0]         removed_out;

    tpcq_ram #(.WIDTH($bits(tpcq_slot_t)), .DEPTH(QUEUE_DEPTH)) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd_bits)
    );

    tpcq_idmap u_idmap (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (idreq),
        .rsp   (idrsp)
    );

    assign rd       = tpcq_slot_t'(rd_bits);
    assign s_tready = (state_reg == TS_IDLE) && idrsp.ready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign dl_sum  = {1'b0, s_tdata[31:0]} + {17'b0, s_tdata[128:113]};
    assign idx_inc = idx_reg + Q_CW'(1);
    assign idx_dec = idx_reg - Q_CW'(1);

    assign new_before = (prio_reg < rd.prio) ||
                        ((prio_reg == rd.prio) && (dl_reg < rd.deadline));
    assign permit     = (rd.actor == actor_reg) || (rd.owner == owner_reg) || priv_reg;

    always_comb
    begin
        priority case (req_reg)
            REQ_GROUP: match = (rd.actor == actor_reg) || (rd.owner == actor_reg);
            REQ_CLEAR: match = 1'b1;
            default:   match = (idx_reg == pos_reg);
        endcase
    end

    assign new_slot.prio     = prio_reg;
    assign new_slot.deadline = dl_reg;
    assign new_slot.job_id   = res_id_reg;
    assign new_slot.actor    = actor_reg;
    assign new_slot.owner    = owner_reg;
    assign new_slot.cause    = cause_reg;
    assign new_slot.payload  = payload_reg;

    assign removed_out = ((req_reg == REQ_GROUP) || (req_reg == REQ_CLEAR)) ?
                         7'(removed_reg) : 7'd0;

    always_comb
    begin
        state_next       = state_reg;
        req_next         = req_reg;
        now_next         = now_reg;
        actor_next       = actor_reg;
        owner_next       = owner_reg;
        cause_next       = cause_reg;
        prio_next        = prio_reg;
        dl_next          = dl_reg;
        payload_next     = payload_reg;
        target_next      = target_reg;
        limit_next       = limit_reg;
        priv_next        = priv_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        wr_next          = wr_reg;
        pos_next         = pos_reg;
        removed_next     = removed_reg;
        res_status_next  = res_status_reg;
        res_id_next      = res_id_reg;
        res_actor_next   = res_actor_reg;
        res_cause_next   = res_cause_reg;
        res_payload_next = res_payload_reg;
        res_prio_next    = res_prio_reg;
        free_id_next     = free_id_reg;
        out_data_next    = out_data_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        ram_we           = 1'b0;
        ram_waddr        = idx_reg[Q_AW-1:0];
        ram_wdata        = rd;
        ram_raddr        = idx_reg[Q_AW-1:0];
        idreq.alloc      = 1'b0;
        idreq.free       = 1'b0;
        idreq.id         = free_id_reg;

        unique case (state_reg)
            TS_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    req_next     = s_tuser;
                    now_next     = s_tdata[31:0];
                    actor_next   = s_tdata[55:32];
                    owner_next   = s_tdata[79:56];
                    cause_next   = s_tdata[104:80];
                    prio_next    = s_tdata[112:105];
                    dl_next      = dl_sum[32] ? 32'hFFFF_FFFF : dl_sum[31:0];
                    payload_next = s_tdata[160:129];
                    target_next  = s_tdata[175:161];
                    limit_next   = s_tdata[183:176];
                    priv_next    = s_tdata[184];
                    state_next   = TS_START;
                end
            end
            TS_START:
            begin
                res_status_next  = ST_OK;
                res_id_next      = '0;
                res_actor_next   = '0;
                res_cause_next   = '0;
                res_payload_next = '0;
                res_prio_next    = '0;
                removed_next     = '0;
                idx_next         = '0;
                wr_next          = '0;
                state_next       = TS_DONE;
                priority case (req_reg)
                    REQ_INSERT:
                    begin
                        if (count_reg == Q_CW'(QUEUE_DEPTH))
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            state_next = TS_INS_REQ;
                        end
                    end
                    REQ_POP:
                    begin
                        res_status_next = ST_NOTREADY;
                        if (count_reg != '0)
                        begin
                            state_next = TS_SRCH_RD;
                        end
                    end
                    REQ_REMOVE:
                    begin
                        res_status_next = ST_NOTFOUND;
                        if (count_reg != '0)
                        begin
                            state_next = TS_SRCH_RD;
                        end
                    end
                    REQ_GROUP:
                    begin
                        state_next = TS_CMP_RD;
                    end
                    REQ_CLEAR:
                    begin
                        if (!priv_reg)
                        begin
                            res_status_next = ST_DENIED;
                        end
                        else
                        begin
                            state_next = TS_CMP_RD;
                        end
                    end
                    default:
                    begin
                        state_next = TS_DONE;
                    end
                endcase
            end
            TS_INS_REQ:
            begin
                idreq.alloc = 1'b1;
                state_next  = TS_INS_WAIT;
            end
            TS_INS_WAIT:
            begin
                if (idrsp.done)
                begin
                    if (!idrsp.found)
                    begin
                        res_status_next = ST_NOID;
                        state_next      = TS_DONE;
                    end
                    else
                    begin
                        res_id_next = idrsp.id;
                        idx_next    = count_reg;
                        state_next  = (count_reg == '0) ? TS_INS_WR : TS_INS_RD;
                    end
                end
            end
            TS_INS_RD:
            begin
                // idx is the candidate position; look at the slot just above it
                ram_raddr  = idx_dec[Q_AW-1:0];
                state_next = TS_INS_EV;
            end
            TS_INS_EV:
            begin
                if (new_before)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = idx_reg[Q_AW-1:0];
                    ram_wdata  = rd;
                    idx_next   = idx_dec;
                    state_next = (idx_dec == '0) ? TS_INS_WR : TS_INS_RD;
                end
                else
                begin
                    state_next = TS_INS_WR;
                end
            end
            TS_INS_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg[Q_AW-1:0];
                ram_wdata  = new_slot;
                count_next = count_reg + Q_CW'(1);
                state_next = TS_DONE;
            end
            TS_SRCH_RD:
            begin
                state_next = TS_SRCH_EV;
            end
            TS_SRCH_EV:
            begin
                if (req_reg == REQ_POP)
                begin
                    if ((idx_reg == '0) && (rd.prio > limit_reg))
                    begin
                        state_next = TS_DONE;
                    end
                    else if (rd.deadline <= now_reg)
                    begin
                        res_status_next  = ST_OK;
                        res_id_next      = rd.job_id;
                        res_actor_next   = rd.actor;
                        res_cause_next   = rd.cause;
                        res_payload_next = rd.payload;
                        res_prio_next    = rd.prio;
                        pos_next         = idx_reg;
                        wr_next          = idx_reg;
                        state_next       = TS_CMP_RD;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = (idx_inc == count_reg) ? TS_DONE : TS_SRCH_RD;
                    end
                end
                else
                begin
                    if (rd.job_id == target_reg)
                    begin
                        if (permit)
                        begin
                            res_status_next = ST_OK;
                            res_id_next     = target_reg;
                            pos_next        = idx_reg;
                            wr_next         = idx_reg;
                            state_next      = TS_CMP_RD;
                        end
                        else
                        begin
                            res_status_next = ST_DENIED;
                            state_next      = TS_DONE;
                        end
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = (idx_inc == count_reg) ? TS_DONE : TS_SRCH_RD;
                    end
                end
            end
            TS_CMP_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    count_next = wr_reg;
                    state_next = TS_DONE;
                end
                else
                begin
                    state_next = TS_CMP_EV;
                end
            end
            TS_CMP_EV:
            begin
                idx_next = idx_inc;
                if (match)
                begin
                    free_id_next = rd.job_id;
                    removed_next = removed_reg + Q_CW'(1);
                    state_next   = TS_CMP_FREE;
                end
                else
                begin
                    // kept slot moves down to the write pointer
                    ram_we     = 1'b1;
                    ram_waddr  = wr_reg[Q_AW-1:0];
                    ram_wdata  = rd;
                    wr_next    = wr_reg + Q_CW'(1);
                    state_next = TS_CMP_RD;
                end
            end
            TS_CMP_FREE:
            begin
                idreq.free = 1'b1;
                state_next = TS_CMP_FWAIT;
            end
            TS_CMP_FWAIT:
            begin
                if (idrsp.done)
                begin
                    state_next = TS_CMP_RD;
                end
            end
            TS_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {6'b0, removed_out, res_prio_reg, res_payload_reg,
                                      res_cause_reg, res_actor_reg, res_id_reg,
                                      res_status_reg};
                    state_next     = TS_IDLE;
                end
            end
            default:
            begin
                state_next = TS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= TS_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        now_reg         <= now_next;
        actor_reg       <= actor_next;
        owner_reg       <= owner_next;
        cause_reg       <= cause_next;
        prio_reg        <= prio_next;
        dl_reg          <= dl_next;
        payload_reg     <= payload_next;
        target_reg      <= target_next;
        limit_reg       <= limit_next;
        priv_reg        <= priv_next;
        idx_reg         <= idx_next;
        wr_reg          <= wr_next;
        pos_reg         <= pos_next;
        removed_reg     <= removed_next;
        res_status_reg  <= res_status_next;
        res_id_reg      <= res_id_next;
        res_actor_reg   <= res_actor_next;
        res_cause_reg   <= res_cause_next;
        res_payload_reg <= res_payload_next;
        res_prio_reg    <= res_prio_next;
        free_id_reg     <= free_id_next;
        out_data_reg    <= out_data_next;
    end

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for timed_priority_command_queue
// Drives requests on the input stream, predicts every result with a behavioral
// copy of the queue, the id bitmap and the allocator cursor, and compares each
// result transfer field by field. Random idling on both sides, one long
// receiver hold-off to fill the block, and a watchdog on stalled progress.
// ----------------------------------------------------------------------------
module testbench;
    import tpcq_pkg::*;

    typedef struct {
        logic [2:0]        req;
        logic [31:0]       now;
        logic [23:0]       actor;
        logic [23:0]       owner;
        logic [24:0]       cause;
        logic signed [7:0] prio;
        logic [15:0]       delay;
        logic [31:0]       payload;
        logic [14:0]       target;
        logic signed [7:0] limit;
        logic              priv;
    } request_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [14:0] job_id;
        logic [23:0] actor;
        logic [24:0] cause;
        logic [31:0] payload;
        logic [7:0]  prio;
        logic [6:0]  removed;
    } result_t;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam logic [2:0] REQ_UNKNOWN = 3'd5;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [119:0] m_tdata;

    // shadow of the queue
    tpcq_slot_t  q_slots[$];
    bit          id_busy[ID_SPACE];
    int unsigned id_next;
    result_t     pending_results[$];

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_off = 1'b0;
    int  mismatches = 0;
    int  idle_cycles = 0;
    int  sent = 0;
    logic [31:0] clock_now = 32'd1000;

    always #4 clk = ~clk;

    timed_priority_command_queue u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    function automatic result_t predict_queue(request_t r);
        result_t     res;
        tpcq_slot_t  s;
        logic [32:0] sum;
        int          pos;
        int          i;
        bit          found;
        res = '{default: '0};
        res.status = ST_OK;
        case (r.req)
            REQ_INSERT:
            begin
                if (q_slots.size() >= QUEUE_DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    found = 1'b0;
                    for (i = 0; i < ID_SPACE; i++)
                    begin
                        if (!id_busy[(id_next + i) % ID_SPACE])
                        begin
                            id_next = (id_next + i) % ID_SPACE;
                            found = 1'b1;
                            break;
                        end
                    end
                    if (!found)
                        res.status = ST_NOID;
                    else
                    begin
                        id_busy[id_next] = 1'b1;
                        sum = {1'b0, r.now} + {17'b0, r.delay};
                        s.prio = r.prio;
                        s.deadline = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                        s.job_id = 15'(id_next);
                        s.actor = r.actor;
                        s.owner = r.owner;
                        s.cause = r.cause;
                        s.payload = r.payload;
                        pos = q_slots.size();
                        for (i = 0; i < q_slots.size(); i++)
                        begin
                            if (s.prio < q_slots[i].prio || (s.prio == q_slots[i].prio
                                && s.deadline < q_slots[i].deadline))
                            begin
                                pos = i;
                                break;
                            end
                        end
                        q_slots.insert(pos, s);
                        res.job_id = 15'(id_next);
                    end
                end
            end
            REQ_POP:
            begin
                res.status = ST_NOTREADY;
                if (q_slots.size() > 0 && q_slots[0].prio <= r.limit)
                begin
                    for (i = 0; i < q_slots.size(); i++)
                    begin
                        if (q_slots[i].deadline <= r.now)
                        begin
                            res.status = ST_OK;
                            res.job_id = q_slots[i].job_id;
                            res.actor = q_slots[i].actor;
                            res.cause = q_slots[i].cause;
                            res.payload = q_slots[i].payload;
                            res.prio = q_slots[i].prio;
                            id_busy[q_slots[i].job_id] = 1'b0;
                            q_slots.delete(i);
                            break;
                        end
                    end
                end
            end
            REQ_REMOVE:
            begin
                res.status = ST_NOTFOUND;
                for (i = 0; i < q_slots.size(); i++)
                begin
                    if (q_slots[i].job_id == r.target)
                    begin
                        if (q_slots[i].actor == r.actor || q_slots[i].owner == r.owner
                            || r.priv)
                        begin
                            res.job_id = r.target;
                            id_busy[r.target] = 1'b0;
                            q_slots.delete(i);
                            res.status = ST_OK;
                        end
                        else
                            res.status = ST_DENIED;
                        break;
                    end
                end
            end
            REQ_GROUP:
            begin
                i = 0;
                while (i < q_slots.size())
                begin
                    if (q_slots[i].actor == r.actor || q_slots[i].owner == r.actor)
                    begin
                        id_busy[q_slots[i].job_id] = 1'b0;
                        q_slots.delete(i);
                        res.removed++;
                    end
                    else
                        i++;
                end
            end
            REQ_CLEAR:
            begin
                if (!r.priv)
                    res.status = ST_DENIED;
                else
                begin
                    foreach (q_slots[j])
                        id_busy[q_slots[j].job_id] = 1'b0;
                    res.removed = 7'(q_slots.size());
                    q_slots.delete();
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // inputs change only at the falling edge, so blocking updates are safe here
    task automatic send_request(request_t r);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            @(negedge clk);
        s_tdata = {7'd0, r.priv, r.limit, r.target, r.payload, r.delay, r.prio, r.cause,
                   r.owner, r.actor, r.now};
        s_tuser = r.req;
        s_tvalid = 1'b1;
        pending_results.push_back(predict_queue(r));
        sent++;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // receiver side
    always @(negedge clk)
        m_tready <= !hold_off && !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status = m_tdata[2:0];
            got.job_id = m_tdata[17:3];
            got.actor = m_tdata[41:18];
            got.cause = m_tdata[66:42];
            got.payload = m_tdata[98:67];
            got.prio = m_tdata[106:99];
            got.removed = m_tdata[113:107];
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer %h", m_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st=%0d id=%0d act=%h cau=%h pay=%h pri=%h cnt=%0d"
                            , want.status, want.job_id, want.actor, want.cause, want.payload,
                            want.prio, want.removed, "\n          got st=%0d id=%0d act=%h",
                            got.status, got.job_id, got.actor, " cau=%h pay=%h pri=%h cnt=%0d",
                            got.cause, got.payload, got.prio, got.removed);
                end
            end
        end
    end

    // watchdog on accepted transfers
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else if (s_tvalid || pending_results.size() > 0)
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // actors drawn from a small set so that ownership checks hit
    function automatic request_t random_request(logic [2:0] kind);
        request_t r;
        r.req = kind;
        r.now = clock_now;
        r.actor = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(7));
        r.owner = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(7));
        r.cause = ($urandom_range(4) == 0) ? '1 : 25'($urandom);
        r.prio = ($urandom_range(3) == 0) ? 8'($urandom) : 8'(int'($urandom_range(6)) - 3);
        r.delay = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(20));
        r.payload = $urandom;
        r.target = (q_slots.size() > 0 && $urandom_range(3) != 0)
                   ? q_slots[$urandom_range(q_slots.size() - 1)].job_id : 15'($urandom);
        r.limit = ($urandom_range(3) == 0) ? 8'($urandom) : 8'sd127;
        r.priv = $urandom_range(1);
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_results.size() > 0)
            @(negedge clk);
    endtask

    task automatic test_directed();
        request_t r;
        int k;
        r = random_request(REQ_POP);
        send_request(r);                       // pop on an empty queue
        r = random_request(REQ_INSERT);
        r.now = 32'hFFFF_FFF0;
        r.delay = 16'hFFFF;                    // deadline saturates
        r.prio = 8'sh80;
        r.actor = 24'hFFFFFF;
        r.owner = 24'hFFFFFF;
        r.cause = '1;
        r.payload = 32'hFFFF_FFFF;
        send_request(r);
        r = random_request(REQ_INSERT);
        r.prio = 8'sh7F;
        r.delay = 16'd0;
        r.cause = 25'h0FF_FFFF;
        r.actor = 24'd0;
        r.owner = 24'd0;
        send_request(r);
        r = random_request(REQ_POP);
        r.limit = 8'sh80;
        r.now = 32'd0;
        send_request(r);                       // nothing ready before deadline
        r.now = 32'hFFFF_FFFF;
        r.limit = 8'sh7F;
        send_request(r);
        r = random_request(REQ_POP);
        r.limit = 8'sh80;                      // head priority above limit
        send_request(r);
        r = random_request(REQ_REMOVE);
        r.target = 15'h7FFF;
        send_request(r);                       // id not in queue
        r = random_request(REQ_INSERT);
        r.actor = 24'd5;
        r.owner = 24'd6;
        r.prio = 8'sh7F;
        r.delay = 16'hFFFF;                    // lands at the tail
        send_request(r);
        r = random_request(REQ_REMOVE);
        r.target = q_slots[q_slots.size() - 1].job_id;
        r.actor = 24'd9;
        r.owner = 24'd9;
        r.priv = 1'b0;
        send_request(r);                       // not permitted
        r.owner = 24'd6;
        send_request(r);                       // owner may remove
        r = random_request(REQ_CLEAR);
        r.priv = 1'b0;
        send_request(r);
        r = random_request(REQ_GROUP);
        r.actor = 24'd1234567;
        send_request(r);                       // empty match
        for (k = 0; k < QUEUE_DEPTH + 2; k++)
            send_request(random_request(REQ_INSERT));   // fills up, then full
        r = random_request(REQ_UNKNOWN);
        send_request(r);
        r.req = 3'd7;
        send_request(r);
        r = random_request(REQ_CLEAR);
        r.priv = 1'b1;
        send_request(r);
        wait_drained();
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct);
        int k;
        int pick;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (k = 0; k < count; k++)
        begin
            if ($urandom_range(3) == 0)
                clock_now = clock_now + $urandom_range(30);
            pick = $urandom_range(99);
            if (pick < 45)
                send_request(random_request(REQ_INSERT));
            else if (pick < 75)
                send_request(random_request(REQ_POP));
            else if (pick < 88)
                send_request(random_request(REQ_REMOVE));
            else if (pick < 95)
                send_request(random_request(REQ_GROUP));
            else if (pick < 98)
                send_request(random_request(REQ_CLEAR));
            else
                send_request(random_request(3'($urandom_range(7, 5))));
        end
        wait_drained();
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        int k;
        hold_off = 1'b1;
        fork
            begin
                repeat (3000) @(negedge clk);
                hold_off = 1'b0;
            end
            for (k = 0; k < 12; k++)
                send_request(random_request(REQ_INSERT));
        join
        wait_drained();
    endtask

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(250, 0, 0);
        test_random(250, 59, 0);
        test_random(250, 0, 59);
        test_random(250, 18, 18);
        test_backpressure();
        wait_drained();
        repeat (2000) @(negedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
